// ===== design/ectw_pkg.sv =====
`timescale 1ns / 1ps

package ectw_pkg;

	// Time-of-day fields that travel beside the date pipeline.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	// Reciprocals for exact division by constants: q = (x * M) >> K.
	// Each one has been checked against the largest operand it ever sees.
	localparam logic [30:0] RECIP_15_K34   = 31'd1145324613;  // t/4 by 15
	localparam logic [25:0] RECIP_15_K29   = 26'd35791395;    // minutes/4 by 15
	localparam logic [17:0] RECIP_3_K19    = 18'd174763;      // hours/8 by 3
	localparam logic [26:0] RECIP_7305_K39 = 27'd75257470;    // year estimate
	localparam logic [29:0] RECIP_E_K34    = 30'd561416000;   // 1000 / 30601
	localparam logic [24:0] RECIP_E601_K25 = 25'd20166555;    // 601 / 1000
	localparam logic [15:0] RECIP_E26_K14  = 16'd42614;       // 26 / 10
	localparam logic [12:0] RECIP_100_K19  = 13'd5243;        // by 100
	localparam logic [10:0] RECIP_7_K13    = 11'd1171;        // by 7

	localparam logic [18:0] JD_A_OFFSET = 19'd102032;
	localparam logic [18:0] JD_A_STEP1  = 19'd146097;
	localparam logic [18:0] JD_A_STEP2  = 19'd292194;
	localparam logic [21:0] JD_B_OFFSET = 22'd2442113;
	localparam logic [25:0] JD_C_OFFSET = 26'd2442;
	localparam logic [12:0] YEAR_BASE   = 13'd4716;
	localparam logic [12:0] YEAR_BASE_N = 13'd4715;

	// Stages the time of day waits between the split and the calendar output.
	localparam int TOD_DELAY = 8;

endpackage

// ===== design/epoch_to_calendar_weekday_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// --------  -----------------  ----------------------------------------------
// input     start / busy       epoch_seconds
// result    done (one cycle)   year_value month_value day_value hour_value
//                              minute_value second_value day_of_week
//
// One beat is taken in every cycle: busy is always low.
// A beat accepted at a clock edge is strobed on done once it has passed the
// thirteen register stages of the divide and calendar pipeline.
// Reset clears only the valid bits, so no result is strobed until a beat passes.
// The receiver cannot stall, so the pipeline never holds and never drops a beat.

module epoch_to_calendar_weekday_unit
	import ectw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [11:0] year_value,
	output logic [3:0]  month_value,
	output logic [4:0]  day_value,
	output logic [4:0]  hour_value,
	output logic [5:0]  minute_value,
	output logic [5:0]  second_value,
	output logic [2:0]  day_of_week
);

	logic        valid_s5;
	logic [15:0] days_s5;
	tod_t        tod_s5;
	tod_t        tod_dly [TOD_DELAY];

	assign busy = 1'b0;

	ectw_time_split u_time_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.epoch_seconds (epoch_seconds),
		.valid_s5      (valid_s5),
		.days_s5       (days_s5),
		.tod_s5        (tod_s5)
	);

	ectw_date_calc u_date_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s5  (valid_s5),
		.days_s5   (days_s5),
		.valid_s13 (done),
		.year_s13  (year_value),
		.month_s13 (month_value),
		.day_s13   (day_value),
		.wday_s13  (day_of_week)
	);

	// The time of day is ready long before the date, so it waits here.
	always_ff @(posedge clk) begin
		tod_dly[0] <= tod_s5;
		for (int i = 1; i < TOD_DELAY; i++) begin
			tod_dly[i] <= tod_dly[i-1];
		end
	end

	assign hour_value   = tod_dly[TOD_DELAY-1].hour;
	assign minute_value = tod_dly[TOD_DELAY-1].minute;
	assign second_value = tod_dly[TOD_DELAY-1].second;

endmodule

// ===== design/ectw_time_split.sv =====
`timescale 1ns / 1ps

module ectw_time_split
	import ectw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] epoch_seconds,
	output logic        valid_s5,
	output logic [15:0] days_s5,
	output tod_t        tod_s5
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [31:0] t_s1, t_s2;
	logic [26:0] q1_s2, q1_s3;
	logic [20:0] q2_s3, q2_s4;
	logic [15:0] days_s4;
	logic [5:0]  sec_s3, sec_s4, min_s4;

	logic [60:0] prod1;
	logic [50:0] prod2;
	logic [35:0] prod3;
	logic [31:0] q1x60;
	logic [26:0] q2x60;
	logic [20:0] daysx24;
	logic [31:0] sec_full;
	logic [26:0] min_full;
	logic [20:0] hour_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Division by 60 is a shift by two and a multiply by the reciprocal of 15.
	assign prod1    = 61'(t_s1[31:2]) * 61'(RECIP_15_K34);
	assign q1x60    = 32'(q1_s2) * 32'd60;
	assign sec_full = t_s2 - q1x60;
	assign prod2    = 51'(q1_s2[26:2]) * 51'(RECIP_15_K29);
	assign q2x60    = 27'(q2_s3) * 27'd60;
	assign min_full = q1_s3 - q2x60;
	assign prod3    = 36'(q2_s3[20:3]) * 36'(RECIP_3_K19);
	assign daysx24  = 21'(days_s4) * 21'd24;
	assign hour_full = q2_s4 - daysx24;

	always_ff @(posedge clk) begin
		t_s1    <= epoch_seconds;
		t_s2    <= t_s1;
		q1_s2   <= prod1[60:34];
		q1_s3   <= q1_s2;
		q2_s3   <= prod2[49:29];
		sec_s3  <= sec_full[5:0];
		q2_s4   <= q2_s3;
		days_s4 <= prod3[34:19];
		sec_s4  <= sec_s3;
		min_s4  <= min_full[5:0];
		days_s5 <= days_s4;
		tod_s5.hour   <= hour_full[4:0];
		tod_s5.minute <= min_s4;
		tod_s5.second <= sec_s4;
	end

endmodule

// ===== design/ectw_date_calc.sv =====
`timescale 1ns / 1ps

module ectw_date_calc
	import ectw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s5,
	input  logic [15:0] days_s5,
	output logic        valid_s13,
	output logic [11:0] year_s13,
	output logic [3:0]  month_s13,
	output logic [4:0]  day_s13,
	output logic [2:0]  wday_s13
);

	logic        valid_s6, valid_s7, valid_s8, valid_s9, valid_s10, valid_s11, valid_s12;
	logic [21:0] b_s6, b_s7, b_s8;
	logic [25:0] x_s7;
	logic [12:0] c_s8, c_s9, c_s10;
	logic [8:0]  d_s9, d_s10;
	logic [4:0]  e_s10;
	logic [4:0]  f_s11, f_s12;
	logic [11:0] year_s11, year_s12;
	logic [3:0]  month_s11, month_s12;
	logic [11:0] ywk_s11;
	logic [5:0]  cent_s11;
	logic [6:0]  t26_s11;
	logic [8:0]  h_s12;

	logic [18:0] a_arg;
	logic [4:0]  a_val;
	logic [21:0] b_next;
	logic [25:0] x_next;
	logic [52:0] prod_c;
	logic [21:0] d_full;
	logic [38:0] prod_e;
	logic [29:0] prod_e601;
	logic [8:0]  f_full;
	logic [12:0] year_lo, year_hi;
	logic [24:0] prod_cent;
	logic [20:0] prod_t26;
	logic [11:0] yoc_full;
	logic [6:0]  yoc;
	logic [8:0]  h_next;
	logic [9:0]  z_val;
	logic [20:0] prod_q7;
	logic [9:0]  wd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
		end else begin
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
		end
	end

	// The century correction term only ever lands on 15, 16 or 17 for a 16-bit
	// day count, so two compares replace the division.
	assign a_arg  = {1'b0, days_s5, 2'b00} + JD_A_OFFSET;
	assign a_val  = 5'd15 + 5'(a_arg >= JD_A_STEP1) + 5'(a_arg >= JD_A_STEP2);
	assign b_next = 22'(days_s5) + JD_B_OFFSET + 22'(a_val) - 22'(a_val[4:2]);

	assign x_next = 26'(b_s6) * 26'd20 - JD_C_OFFSET;
	assign prod_c = 53'(x_s7) * 53'(RECIP_7305_K39);

	assign d_full = b_s8 - 22'(c_s8) * 22'd365 - 22'(c_s8[12:2]);

	// e = floor(d * 1000 / 30601), folded into one constant multiply.
	assign prod_e = 39'(d_s9) * 39'(RECIP_E_K34);

	assign prod_e601 = 30'(e_s10) * 30'(RECIP_E601_K25);
	assign f_full    = d_s10 - 9'(e_s10) * 9'd30 - 9'(prod_e601[29:25]);
	assign year_lo   = c_s10 - YEAR_BASE;
	assign year_hi   = c_s10 - YEAR_BASE_N;

	// The weekday congruence always sees the March-based year and month, that is
	// year c - 4716 and month e - 1, so (month + 1) is e itself.
	assign prod_cent = 25'(year_lo[11:0]) * 25'(RECIP_100_K19);
	assign prod_t26  = 21'(e_s10) * 21'(RECIP_E26_K14);

	assign yoc_full = ywk_s11 - 12'(cent_s11) * 12'd100;
	assign yoc      = yoc_full[6:0];
	assign h_next   = 9'(f_s11) + 9'(t26_s11) + 9'(yoc) + 9'(yoc[6:2])
		+ 9'(cent_s11) * 9'd5 + 9'(cent_s11[5:2]);

	// Saturday is zero in the congruence; the offset of five and the added one move Monday to one.
	assign z_val   = 10'(h_s12) + 10'd5;
	assign prod_q7 = 21'(z_val) * 21'(RECIP_7_K13);
	assign wd_full = z_val - 10'(prod_q7[20:13]) * 10'd7 + 10'd1;

	always_ff @(posedge clk) begin
		b_s6  <= b_next;
		b_s7  <= b_s6;
		x_s7  <= x_next;
		b_s8  <= b_s7;
		c_s8  <= prod_c[51:39];
		c_s9  <= c_s8;
		d_s9  <= d_full[8:0];
		c_s10 <= c_s9;
		d_s10 <= d_s9;
		e_s10 <= prod_e[38:34];
		f_s11 <= f_full[4:0];
		if (e_s10 <= 5'd13) begin
			year_s11  <= year_lo[11:0];
			month_s11 <= 4'(e_s10 - 5'd1);
		end else begin
			year_s11  <= year_hi[11:0];
			month_s11 <= 4'(e_s10 - 5'd13);
		end
		ywk_s11   <= year_lo[11:0];
		cent_s11  <= prod_cent[24:19];
		t26_s11   <= prod_t26[20:14];
		f_s12     <= f_s11;
		year_s12  <= year_s11;
		month_s12 <= month_s11;
		h_s12     <= h_next;
		day_s13   <= f_s12;
		year_s13  <= year_s12;
		month_s13 <= month_s12;
		wday_s13  <= wd_full[2:0];
	end

endmodule
